// ----- src/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, action and status codes and the pipeline item type of the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 2;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int SQ_W       = PROD_W - 1;
    localparam int QUO_W      = DATA_W + 1;
    localparam int SREM_W     = DATA_W + 4;
    localparam int SQRT_STEPS = DATA_W;
    localparam int FIRST_ITER = 3;
    localparam int NUM_STAGES = FIRST_ITER + QUO_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_MAG = 3'd4
    } action_t;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } sat_t;

    typedef struct {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W:0]   sum_re;
        logic signed [DATA_W:0]   sum_im;
        logic signed [PROD_W-1:0] p_rr;
        logic signed [PROD_W-1:0] p_ii;
        logic signed [PROD_W-1:0] p_ri;
        logic signed [PROD_W-1:0] p_ir;
        logic [SQ_W-1:0]          sq_ar;
        logic [SQ_W-1:0]          sq_ai;
        logic [SQ_W-1:0]          sq_br;
        logic [SQ_W-1:0]          sq_bi;
        logic signed [WIDE_W-1:0] m_re;
        logic signed [WIDE_W-1:0] m_im;
        logic signed [WIDE_W-1:0] d_re;
        logic signed [WIDE_W-1:0] d_im;
        logic [PROD_W-1:0]        den;
        logic [PROD_W-1:0]        rad;
        logic [DATA_W-1:0]        fin_re;
        logic [DATA_W-1:0]        fin_im;
        logic                     fin_sat;
        logic                     dz;
        logic                     neg_re;
        logic                     neg_im;
        logic                     ovf_re;
        logic                     ovf_im;
        logic [PROD_W-1:0]        rem_re;
        logic [PROD_W-1:0]        rem_im;
        logic [QUO_W-1:0]         nlo_re;
        logic [QUO_W-1:0]         nlo_im;
        logic [QUO_W-1:0]         q_re;
        logic [QUO_W-1:0]         q_im;
        logic [SREM_W-1:0]        srem;
        logic [DATA_W-1:0]        root;
    } item_t;

endpackage

// ----- src/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined add, subtract, multiply, divide and magnitude on Q16.16 complex
// operands with saturation and status.
// ----------------------------------------------------------------------------
// The unit takes one operation per clock cycle while no result is stalled and
// returns its results in order. The depth is set by the divide and square
// root, which resolve one quotient bit per pipeline stage over 33 stages and
// one root bit per stage in all but the last of them, after three stages of
// products, sums and operand preparation; the first stage loads at the input
// transfer and the result register follows the last divider stage. A stall on
// the result side holds the whole pipeline, and s_ready is low only while a
// finished result waits on m_ready.
module complex_arithmetic_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [cau_pkg::ACT_W-1:0]            s_action,
    input  logic signed [cau_pkg::DATA_W-1:0]    s_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0]    s_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0]    s_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0]    s_b_im,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cau_pkg::DATA_W-1:0]    m_res_re,
    output logic signed [cau_pkg::DATA_W-1:0]    m_res_im,
    output logic [cau_pkg::STAT_W-1:0]           m_status
);
    import cau_pkg::*;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MAX =
        {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN =
        {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] QPOS_MAX = {2'b00, {(DATA_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] QNEG_MAX = {2'b01, {(DATA_W-1){1'b0}}};
    localparam int               REM_SH   = QUO_W - FRAC_W;

    function automatic sat_t saturate(input logic signed [WIDE_W-1:0] x);
        sat_t r;
        if (x > WIDE_MAX) begin
            r.val = VAL_MAX;
            r.sat = 1'b1;
        end else if (x < WIDE_MIN) begin
            r.val = VAL_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = x[DATA_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t div_result(input logic neg, input logic ovf,
                                        input logic [QUO_W-1:0] q);
        sat_t r;
        if (ovf || (neg && q > QNEG_MAX) || (!neg && q > QPOS_MAX)) begin
            r.val = neg ? VAL_MIN : VAL_MAX;
            r.sat = 1'b1;
        end else begin
            r.val = neg ? DATA_W'(-q) : q[DATA_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    item_t                 st_reg  [NUM_STAGES];
    item_t                 st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  m_valid_reg;
    logic [DATA_W-1:0]     res_re_reg, res_re_next;
    logic [DATA_W-1:0]     res_im_reg, res_im_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic                  advance;

    // the whole pipeline moves unless a finished result is stalled
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // products, squares and add/subtract sums
    always_comb begin
        st_next[0] = st_reg[0];
        st_next[0].action = s_action;
        if (s_action == ACT_SUB) begin
            st_next[0].sum_re = (DATA_W+1)'(s_a_re) - (DATA_W+1)'(s_b_re);
            st_next[0].sum_im = (DATA_W+1)'(s_a_im) - (DATA_W+1)'(s_b_im);
        end else begin
            st_next[0].sum_re = (DATA_W+1)'(s_a_re) + (DATA_W+1)'(s_b_re);
            st_next[0].sum_im = (DATA_W+1)'(s_a_im) + (DATA_W+1)'(s_b_im);
        end
        st_next[0].p_rr  = PROD_W'(s_a_re) * PROD_W'(s_b_re);
        st_next[0].p_ii  = PROD_W'(s_a_im) * PROD_W'(s_b_im);
        st_next[0].p_ri  = PROD_W'(s_a_re) * PROD_W'(s_b_im);
        st_next[0].p_ir  = PROD_W'(s_a_im) * PROD_W'(s_b_re);
        st_next[0].sq_ar = SQ_W'(PROD_W'(s_a_re) * PROD_W'(s_a_re));
        st_next[0].sq_ai = SQ_W'(PROD_W'(s_a_im) * PROD_W'(s_a_im));
        st_next[0].sq_br = SQ_W'(PROD_W'(s_b_re) * PROD_W'(s_b_re));
        st_next[0].sq_bi = SQ_W'(PROD_W'(s_b_im) * PROD_W'(s_b_im));
    end

    // combine products
    always_comb begin
        st_next[1] = st_reg[0];
        st_next[1].m_re = WIDE_W'(st_reg[0].p_rr) - WIDE_W'(st_reg[0].p_ii);
        st_next[1].m_im = WIDE_W'(st_reg[0].p_ri) + WIDE_W'(st_reg[0].p_ir);
        st_next[1].d_re = WIDE_W'(st_reg[0].p_rr) + WIDE_W'(st_reg[0].p_ii);
        st_next[1].d_im = WIDE_W'(st_reg[0].p_ir) - WIDE_W'(st_reg[0].p_ri);
        st_next[1].den  = PROD_W'(st_reg[0].sq_br) + PROD_W'(st_reg[0].sq_bi);
        st_next[1].rad  = PROD_W'(st_reg[0].sq_ar) + PROD_W'(st_reg[0].sq_ai);
    end

    // finish add/sub/multiply, set up the dividers and the square root
    always_comb begin
        sat_t              s_re;
        sat_t              s_im;
        logic [PROD_W-1:0] mag_re;
        logic [PROD_W-1:0] mag_im;
        st_next[2] = st_reg[1];
        unique case (st_reg[1].action)
            ACT_ADD, ACT_SUB: begin
                s_re = saturate(WIDE_W'(st_reg[1].sum_re));
                s_im = saturate(WIDE_W'(st_reg[1].sum_im));
            end
            ACT_MUL: begin
                // arithmetic shift floors toward minus infinity
                s_re = saturate(st_reg[1].m_re >>> FRAC_W);
                s_im = saturate(st_reg[1].m_im >>> FRAC_W);
            end
            default: begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        st_next[2].fin_re  = s_re.val;
        st_next[2].fin_im  = s_im.val;
        st_next[2].fin_sat = s_re.sat || s_im.sat;
        st_next[2].dz      = st_reg[1].den == '0;
        st_next[2].neg_re  = st_reg[1].d_re[WIDE_W-1];
        st_next[2].neg_im  = st_reg[1].d_im[WIDE_W-1];
        mag_re = st_reg[1].d_re[WIDE_W-1] ? PROD_W'(-st_reg[1].d_re)
                                          : PROD_W'(st_reg[1].d_re);
        mag_im = st_reg[1].d_im[WIDE_W-1] ? PROD_W'(-st_reg[1].d_im)
                                          : PROD_W'(st_reg[1].d_im);
        st_next[2].rem_re = mag_re >> REM_SH;
        st_next[2].rem_im = mag_im >> REM_SH;
        st_next[2].nlo_re = {mag_re[REM_SH-1:0], {FRAC_W{1'b0}}};
        st_next[2].nlo_im = {mag_im[REM_SH-1:0], {FRAC_W{1'b0}}};
        // quotient would need more than QUO_W bits
        st_next[2].ovf_re = (mag_re >> REM_SH) >= st_reg[1].den;
        st_next[2].ovf_im = (mag_im >> REM_SH) >= st_reg[1].den;
        st_next[2].q_re   = '0;
        st_next[2].q_im   = '0;
        st_next[2].srem   = '0;
        st_next[2].root   = '0;
    end

    // one quotient bit per stage, one root bit per stage in all but the last stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_iter
        always_comb begin
            logic [PROD_W:0]   w_re;
            logic [PROD_W:0]   w_im;
            logic [PROD_W:0]   d_ext;
            logic              qb_re;
            logic              qb_im;
            st_next[FIRST_ITER+k] = st_reg[FIRST_ITER+k-1];
            d_ext = {1'b0, st_reg[FIRST_ITER+k-1].den};
            w_re  = {st_reg[FIRST_ITER+k-1].rem_re, st_reg[FIRST_ITER+k-1].nlo_re[QUO_W-1]};
            w_im  = {st_reg[FIRST_ITER+k-1].rem_im, st_reg[FIRST_ITER+k-1].nlo_im[QUO_W-1]};
            qb_re = w_re >= d_ext;
            qb_im = w_im >= d_ext;
            st_next[FIRST_ITER+k].rem_re = qb_re ? PROD_W'(w_re - d_ext) : w_re[PROD_W-1:0];
            st_next[FIRST_ITER+k].rem_im = qb_im ? PROD_W'(w_im - d_ext) : w_im[PROD_W-1:0];
            st_next[FIRST_ITER+k].nlo_re = st_reg[FIRST_ITER+k-1].nlo_re << 1;
            st_next[FIRST_ITER+k].nlo_im = st_reg[FIRST_ITER+k-1].nlo_im << 1;
            st_next[FIRST_ITER+k].q_re =
                {st_reg[FIRST_ITER+k-1].q_re[QUO_W-2:0], qb_re};
            st_next[FIRST_ITER+k].q_im =
                {st_reg[FIRST_ITER+k-1].q_im[QUO_W-2:0], qb_im};
            if (k < SQRT_STEPS) begin
                logic [SREM_W-1:0] sw;
                logic [SREM_W-1:0] trial;
                sw    = {st_reg[FIRST_ITER+k-1].srem[SREM_W-3:0],
                         st_reg[FIRST_ITER+k-1].rad[PROD_W-1 -: 2]};
                trial = SREM_W'({st_reg[FIRST_ITER+k-1].root, 2'b01});
                st_next[FIRST_ITER+k].rad = st_reg[FIRST_ITER+k-1].rad << 2;
                if (sw >= trial) begin
                    st_next[FIRST_ITER+k].srem = sw - trial;
                    st_next[FIRST_ITER+k].root =
                        {st_reg[FIRST_ITER+k-1].root[DATA_W-2:0], 1'b1};
                end else begin
                    st_next[FIRST_ITER+k].srem = sw;
                    st_next[FIRST_ITER+k].root =
                        {st_reg[FIRST_ITER+k-1].root[DATA_W-2:0], 1'b0};
                end
            end
        end
    end

    // result selection
    always_comb begin
        sat_t dv_re;
        sat_t dv_im;
        dv_re = div_result(st_reg[NUM_STAGES-1].neg_re, st_reg[NUM_STAGES-1].ovf_re,
                           st_reg[NUM_STAGES-1].q_re);
        dv_im = div_result(st_reg[NUM_STAGES-1].neg_im, st_reg[NUM_STAGES-1].ovf_im,
                           st_reg[NUM_STAGES-1].q_im);
        res_re_next = '0;
        res_im_next = '0;
        status_next = ST_OK;
        unique case (st_reg[NUM_STAGES-1].action)
            ACT_ADD, ACT_SUB, ACT_MUL: begin
                res_re_next = st_reg[NUM_STAGES-1].fin_re;
                res_im_next = st_reg[NUM_STAGES-1].fin_im;
                status_next = st_reg[NUM_STAGES-1].fin_sat ? ST_SAT : ST_OK;
            end
            ACT_DIV: begin
                if (st_reg[NUM_STAGES-1].dz) begin
                    status_next = ST_DIVZ;
                end else begin
                    res_re_next = dv_re.val;
                    res_im_next = dv_im.val;
                    status_next = (dv_re.sat || dv_im.sat) ? ST_SAT : ST_OK;
                end
            end
            ACT_MAG: begin
                res_re_next = st_reg[NUM_STAGES-1].root[DATA_W-1] ? VAL_MAX
                                                                  : st_reg[NUM_STAGES-1].root;
                status_next = st_reg[NUM_STAGES-1].root[DATA_W-1] ? ST_SAT : ST_OK;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            vld_reg     <= {vld_reg[NUM_STAGES-2:0], s_valid};
            m_valid_reg <= vld_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st_reg     <= st_next;
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_res_re = res_re_reg;
    assign m_res_im = res_im_reg;
    assign m_status = status_reg;

endmodule

// ----- src/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [cau_pkg::DATA_W-1:0] m_res_re,
    input logic signed [cau_pkg::DATA_W-1:0] m_res_im,
    input logic [cau_pkg::STAT_W-1:0]        m_status
);
    import cau_pkg::*;

    // a result waits until its transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // input side only stalls behind a waiting result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_DIVZ || m_status == ST_SAT))
        else $error("undefined status code");

    a_divz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIVZ |-> m_res_re == '0 && m_res_im == '0)
        else $error("division by zero with nonzero result");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ----- test/complex_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Drives operand pairs into the complex arithmetic unit with random idling on
// both channels and checks every result against an in-line predictor of the
// add, subtract, multiply, divide and magnitude operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;

    import cau_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic [STAT_W-1:0] st;
    } cau_result_t;

    class cau_scoreboard;
        cau_result_t result_q[$];
        int          errors;

        function logic [DATA_W-1:0] clamp(input logic signed [127:0] v, inout bit sat);
            if (v > 128'sd2147483647) begin
                sat = 1;
                return 32'h7fffffff;
            end else if (v < -128'sd2147483648) begin
                sat = 1;
                return 32'h80000000;
            end
            return v[DATA_W-1:0];
        endfunction

        // truncating quotient of (num << FRAC_W) / den
        function logic signed [127:0] quotient(input logic signed [127:0] num,
                                               input logic [127:0] den);
            logic [127:0] mag;
            logic [127:0] q;
            mag = (num < 0) ? -num : num;
            q   = (mag << FRAC_W) / den;
            return (num < 0) ? -$signed(q) : $signed(q);
        endfunction

        function logic [63:0] root_floor(input logic [127:0] s);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if ({64'd0, t} * {64'd0, t} <= s) r = t;
            end
            return r;
        endfunction

        function void note(input logic [ACT_W-1:0] action,
                           input logic signed [DATA_W-1:0] ar, ai, br, bi);
            logic signed [127:0] xar, xai, xbr, xbi, vre, vim;
            logic [127:0]        den;
            cau_result_t         r;
            bit                  sat;
            xar = ar;
            xai = ai;
            xbr = br;
            xbi = bi;
            sat = 0;
            r.re = '0;
            r.im = '0;
            r.st = ST_OK;
            case (action)
                ACT_ADD: begin
                    r.re = clamp(xar + xbr, sat);
                    r.im = clamp(xai + xbi, sat);
                end
                ACT_SUB: begin
                    r.re = clamp(xar - xbr, sat);
                    r.im = clamp(xai - xbi, sat);
                end
                ACT_MUL: begin
                    vre = (xar * xbr - xai * xbi) >>> FRAC_W;
                    vim = (xar * xbi + xai * xbr) >>> FRAC_W;
                    r.re = clamp(vre, sat);
                    r.im = clamp(vim, sat);
                end
                ACT_DIV: begin
                    den = xbr * xbr + xbi * xbi;
                    if (den == 0) begin
                        r.st = ST_DIVZ;
                    end else begin
                        r.re = clamp(quotient(xar * xbr + xai * xbi, den), sat);
                        r.im = clamp(quotient(xai * xbr - xar * xbi, den), sat);
                    end
                end
                ACT_MAG: begin
                    vre = {64'd0, root_floor(xar * xar + xai * xai)};
                    r.re = clamp(vre, sat);
                end
                default: ;
            endcase
            if (sat) r.st = ST_SAT;
            result_q.push_back(r);
        endfunction

        function void check(input logic [DATA_W-1:0] re, im, input logic [STAT_W-1:0] st);
            cau_result_t e;
            if (result_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = result_q.pop_front();
            if (re !== e.re) begin
                $error("res_re expected %h got %h", e.re, re);
                errors++;
            end
            if (im !== e.im) begin
                $error("res_im expected %h got %h", e.im, im);
                errors++;
            end
            if (st !== e.st) begin
                $error("status expected %0d got %0d", e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [ACT_W-1:0]         s_action;
    logic signed [DATA_W-1:0] s_a_re, s_a_im, s_b_re, s_b_im;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_res_re, m_res_im;
    logic [STAT_W-1:0]        m_status;
    bit                       idle_on;

    cau_scoreboard sb = new();

    complex_arithmetic_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_action(s_action),
        .s_a_re  (s_a_re),
        .s_a_im  (s_a_im),
        .s_b_re  (s_b_re),
        .s_b_im  (s_b_im),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res_re(m_res_re),
        .m_res_im(m_res_im),
        .m_status(m_status)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note(s_action, s_a_re, s_a_im, s_b_re, s_b_im);
        if (aresetn && m_valid && m_ready)
            sb.check(m_res_re, m_res_im, m_status);
    end

    task automatic send_op(input logic [ACT_W-1:0] act,
                           input logic signed [DATA_W-1:0] ar, ai, br, bi);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_a_re   <= ar;
        s_a_im   <= ai;
        s_b_re   <= br;
        s_b_im   <= bi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
            3: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    3: return 32'sh00010000;
                    default: return -32'sh00010000;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
        endcase
    endfunction

    // idling on the result side
    initial begin
        m_ready = 1'b1;
        @(posedge aresetn);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic signed [DATA_W-1:0] bi;
        logic [ACT_W-1:0]         act;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_action = '0;
        s_a_re   = '0;
        s_a_im   = '0;
        s_b_re   = '0;
        s_b_im   = '0;
        idle_on  = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(ACT_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh00000001, -32'sd1);
        send_op(ACT_ADD, 32'sh00018000, -32'sh00020000, 32'sh00004000, 32'sh00010000);
        send_op(ACT_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, -32'sd1);
        send_op(ACT_SUB, 32'sh00030000, 32'sh00010000, 32'sh00010000, 32'sh00030000);
        send_op(ACT_MUL, 32'sh00020000, 32'sh00030000, 32'sh00040000, -32'sh00010000);
        send_op(ACT_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_op(ACT_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_op(ACT_MUL, -32'sd1, 32'sd3, 32'sd1, 32'sd0);
        send_op(ACT_MUL, 32'sh00018000, 32'sd0, 32'sh00020000, 32'sd0);
        send_op(ACT_DIV, 32'sh00010000, 32'sh00010000, 32'sd0, 32'sd0);
        send_op(ACT_DIV, 32'sh00030000, 32'sh00040000, 32'sh00010000, 32'sh00020000);
        send_op(ACT_DIV, 32'sh7fffffff, 32'sh80000000, 32'sd1, 32'sd0);
        send_op(ACT_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_op(ACT_DIV, -32'sd1, 32'sd1, 32'sh7fffffff, 32'sh7fffffff);
        send_op(ACT_DIV, 32'sh00010000, 32'sd0, 32'sh00030000, 32'sd0);
        send_op(ACT_MAG, 32'sh00030000, 32'sh00040000, 32'sd0, 32'sd0);
        send_op(ACT_MAG, 32'sh80000000, 32'sh80000000, 32'sd5, 32'sd7);
        send_op(ACT_MAG, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0);
        send_op(ACT_MAG, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_op(ACT_MAG, -32'sd2, 32'sd0, 32'sd0, 32'sd0);
        send_op(3'd5, 32'sh12345678, 32'sh7fffffff, 32'sd1, 32'sd1);
        send_op(3'd6, 32'sh80000000, -32'sd1, 32'sd0, 32'sd0);
        send_op(3'd7, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);

        for (int i = 0; i < 1900; i++) begin
            if (i == 900) begin
                // hold off until the pipeline has drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.result_q.size() != 0) @(posedge aclk);
            end
            if (i == 1600) idle_on = 1'b0;
            act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            bi = ($urandom_range(0, 4) == 0) ? 32'sd0 : rand_operand();
            send_op(act, rand_operand(), rand_operand(), rand_operand(), bi);
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (sb.result_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
